[sv/bba_pkg.sv]
package bba_pkg;

  localparam int MAX_ORDER    = 20;
  localparam int MIN_ORDER    = 7;
  localparam int HEADER_BYTES = 64;
  localparam int ALIGN_LIMIT  = 64;

  localparam int IDX_W   = MAX_ORDER - MIN_ORDER;
  localparam int SLOTS   = 1 << IDX_W;
  localparam int ORD_W   = 5;
  localparam int ADDR_W  = 48;
  localparam int REQ_W   = 25;
  localparam int CNT_W   = 21;
  localparam int LINK_W  = IDX_W + 1;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EXHAUSTED = 3'd1;
  localparam logic [2:0] ST_DOUBLE    = 3'd2;
  localparam logic [2:0] ST_NOT_OWNED = 3'd3;
  localparam logic [2:0] ST_LOCKED    = 3'd4;

  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_ORDER = 2'd1;
  localparam logic [1:0] REG_LOCK  = 2'd2;

  typedef struct packed {
    logic              free;
    logic [ORD_W-1:0]  ord;
    logic [LINK_W-1:0] link;
  } blk_entry_t;

  function automatic logic [ORD_W-1:0] clamp_order(input logic [ORD_W-1:0] o);
    logic [ORD_W-1:0] r;
    r = o;
    if (o < ORD_W'(MIN_ORDER)) r = ORD_W'(MIN_ORDER);
    else if (o > ORD_W'(MAX_ORDER)) r = ORD_W'(MAX_ORDER);
    return r;
  endfunction

  // Smallest order whose block holds the request, never below the minimum.
  function automatic logic [ORD_W-1:0] fit_order(input logic [REQ_W-1:0] req);
    logic [ORD_W-1:0] o;
    o = ORD_W'(MIN_ORDER);
    for (int i = MIN_ORDER; i < REQ_W - 1; i++) begin
      if (req > (REQ_W'(1) << i)) o = ORD_W'(i + 1);
    end
    return o;
  endfunction

endpackage

[sv/bba_ram.sv]
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[sv/buddy_block_allocator_unit.sv]
// Buddy allocator: one beat in, one beat out. Block headers (free bit, order,
// free-list link) sit in one 8192-entry RAM with a registered read; the list
// heads for each order are flip-flops. A free reads the block header, checks
// it and writes it back; an allocate decodes, searches the lists, pops a
// block, splits it down one order at a time, pushing one buddy header per
// split through the single RAM write port, and writes the final header. After
// reset the block writes the root header before it takes its first beat.
// Base and order settings take effect at the next region reset; the lock at once.
module buddy_block_allocator_unit import bba_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [ADDR_W-1:0]   cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_opcode,
  input  logic [23:0]         in_request_bytes,
  input  logic [15:0]         in_request_alignment,
  input  logic [ADDR_W-1:0]   in_free_address,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_status,
  output logic [ADDR_W-1:0]   out_payload_address,
  output logic [CNT_W-1:0]    out_live_bytes,
  output logic [CNT_W-1:0]    out_peak_bytes,
  output logic [31:0]         out_allocation_count,
  output logic                out_exhausted_flag
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_SEARCH = 4'd3;
  localparam logic [3:0] S_POP    = 4'd4;
  localparam logic [3:0] S_SPLIT  = 4'd5;
  localparam logic [3:0] S_FINAL  = 4'd6;
  localparam logic [3:0] S_FCHK   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]            state_r, state_nxt;
  logic [ADDR_W-1:0]     base_cfg_r, base_cfg_nxt;
  logic [ORD_W-1:0]      order_cfg_r, order_cfg_nxt;
  logic                  lock_r, lock_nxt;
  logic [ADDR_W-1:0]     cur_base_r, cur_base_nxt;
  logic [ORD_W-1:0]      cur_order_r, cur_order_nxt;
  logic [MAX_ORDER:0]    head_valid_r, head_valid_nxt;
  logic [IDX_W-1:0]      head_idx_r [MAX_ORDER+1];
  logic [IDX_W-1:0]      head_idx_nxt [MAX_ORDER+1];
  logic [CNT_W-1:0]      live_r, live_nxt;
  logic [CNT_W-1:0]      peak_r, peak_nxt;
  logic [31:0]           count_r, count_nxt;
  logic                  sticky_r, sticky_nxt;

  logic [1:0]            op_r, op_nxt;
  logic [23:0]           bytes_r, bytes_nxt;
  logic [15:0]           align_r, align_nxt;
  logic [ADDR_W-1:0]     faddr_r, faddr_nxt;
  logic [ORD_W-1:0]      req_order_r, req_order_nxt;
  logic [ORD_W-1:0]      avail_r, avail_nxt;
  logic [IDX_W-1:0]      blk_r, blk_nxt;
  logic [2:0]            res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]     res_addr_r, res_addr_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [2:0]            out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]     out_addr_r, out_addr_nxt;
  logic [CNT_W-1:0]      out_live_r, out_live_nxt;
  logic [CNT_W-1:0]      out_peak_r, out_peak_nxt;
  logic [31:0]           out_count_r, out_count_nxt;
  logic                  out_sticky_r, out_sticky_nxt;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  blk_entry_t            ram_wdata, ram_rdata;

  logic [REQ_W-1:0]      required;
  logic [REQ_W-1:0]      cap_req;
  logic [ADDR_W-1:0]     cap_addr, diff, rel;
  logic [MAX_ORDER:0]    cand;
  logic                  cand_any;
  logic [ORD_W-1:0]      cand_ord;
  logic [ORD_W-1:0]      split_ord;
  logic [ORD_W-1:0]      free_ord;
  logic [CNT_W-1:0]      free_size;
  logic [CNT_W-1:0]      alloc_size;
  logic [CNT_W-1:0]      live_sum;
  logic [ORD_W-1:0]      buddy_sh;
  logic [IDX_W-1:0]      buddy;

  bba_ram #(.WIDTH($bits(blk_entry_t)), .DEPTH(SLOTS)) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign required = REQ_W'(bytes_r) + REQ_W'(HEADER_BYTES);
  assign cap_req  = REQ_W'(1) << cur_order_r;
  assign cap_addr = ADDR_W'(1) << cur_order_r;
  assign diff     = faddr_r - cur_base_r;
  assign rel      = diff - ADDR_W'(HEADER_BYTES);

  // First non-empty list between the fitted order and the region order.
  always_comb begin
    cand_any = 1'b0;
    cand_ord = '0;
    for (int i = 0; i <= MAX_ORDER; i++) begin
      cand[i] = head_valid_r[i] && (ORD_W'(i) >= req_order_r) && (ORD_W'(i) <= cur_order_r);
    end
    for (int i = MAX_ORDER; i >= 0; i--) begin
      if (cand[i]) begin
        cand_any = 1'b1;
        cand_ord = ORD_W'(i);
      end
    end
  end

  assign split_ord  = avail_r - ORD_W'(1);
  assign buddy_sh   = avail_r - ORD_W'(MIN_ORDER + 1);
  assign buddy      = blk_r + (IDX_W'(1) << buddy_sh);
  assign free_ord   = clamp_order(ram_rdata.ord);
  assign free_size  = CNT_W'(1) << free_ord;
  assign alloc_size = CNT_W'(1) << req_order_r;
  assign live_sum   = live_r + alloc_size;

  always_comb begin
    state_nxt      = state_r;
    base_cfg_nxt   = base_cfg_r;
    order_cfg_nxt  = order_cfg_r;
    lock_nxt       = lock_r;
    cur_base_nxt   = cur_base_r;
    cur_order_nxt  = cur_order_r;
    head_valid_nxt = head_valid_r;
    head_idx_nxt   = head_idx_r;
    live_nxt       = live_r;
    peak_nxt       = peak_r;
    count_nxt      = count_r;
    sticky_nxt     = sticky_r;
    op_nxt         = op_r;
    bytes_nxt      = bytes_r;
    align_nxt      = align_r;
    faddr_nxt      = faddr_r;
    req_order_nxt  = req_order_r;
    avail_nxt      = avail_r;
    blk_nxt        = blk_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_live_nxt   = out_live_r;
    out_peak_nxt   = out_peak_r;
    out_count_nxt  = out_count_r;
    out_sticky_nxt = out_sticky_r;
    ram_we         = 1'b0;
    ram_waddr      = blk_r;
    ram_wdata      = '0;
    ram_raddr      = blk_r;

    if (cfg_we) begin
      unique case (cfg_addr)
        REG_BASE:  base_cfg_nxt = cfg_wdata;
        REG_ORDER: order_cfg_nxt = cfg_wdata[ORD_W-1:0];
        REG_LOCK:  lock_nxt = cfg_wdata[0];
        default:   ;
      endcase
    end

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '{free: 1'b1, ord: cur_order_r, link: '0};
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode;
          bytes_nxt = in_request_bytes;
          align_nxt = in_request_alignment;
          faddr_nxt = in_free_address;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        res_addr_nxt = '0;
        state_nxt    = S_DONE;
        unique case (op_r)
          OP_ALLOC: begin
            if (align_r > 16'(ALIGN_LIMIT) || required > cap_req) begin
              sticky_nxt     = 1'b1;
              res_status_nxt = ST_EXHAUSTED;
            end else begin
              req_order_nxt = fit_order(required);
              state_nxt     = S_SEARCH;
            end
          end
          OP_FREE: begin
            if (faddr_r < cur_base_r || diff >= cap_addr ||
                diff < ADDR_W'(HEADER_BYTES) || rel[MIN_ORDER-1:0] != '0) begin
              res_status_nxt = ST_NOT_OWNED;
            end else begin
              blk_nxt   = rel[MIN_ORDER+IDX_W-1:MIN_ORDER];
              ram_raddr = rel[MIN_ORDER+IDX_W-1:MIN_ORDER];
              state_nxt = S_FCHK;
            end
          end
          OP_RESET: begin
            if (lock_r) begin
              res_status_nxt = ST_LOCKED;
            end else begin
              cur_base_nxt   = base_cfg_r;
              cur_order_nxt  = clamp_order(order_cfg_r);
              live_nxt       = '0;
              peak_nxt       = '0;
              count_nxt      = '0;
              sticky_nxt     = 1'b0;
              head_valid_nxt = '0;
              head_valid_nxt[clamp_order(order_cfg_r)] = 1'b1;
              head_idx_nxt[clamp_order(order_cfg_r)]   = '0;
              ram_we         = 1'b1;
              ram_waddr      = '0;
              ram_wdata      = '{free: 1'b1, ord: clamp_order(order_cfg_r), link: '0};
              res_status_nxt = ST_OK;
            end
          end
          default: res_status_nxt = ST_EXHAUSTED;
        endcase
      end
      S_SEARCH: begin
        if (!cand_any) begin
          sticky_nxt     = 1'b1;
          res_status_nxt = ST_EXHAUSTED;
          state_nxt      = S_DONE;
        end else begin
          avail_nxt = cand_ord;
          blk_nxt   = head_idx_r[cand_ord];
          ram_raddr = head_idx_r[cand_ord];
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        head_valid_nxt[avail_r] = ram_rdata.link[IDX_W];
        head_idx_nxt[avail_r]   = ram_rdata.link[IDX_W-1:0];
        state_nxt = (avail_r > req_order_r) ? S_SPLIT : S_FINAL;
      end
      S_SPLIT: begin
        // Push the upper half onto the list one order down.
        ram_we    = 1'b1;
        ram_waddr = buddy;
        ram_wdata = '{free: 1'b1, ord: split_ord,
                      link: {head_valid_r[split_ord], head_idx_r[split_ord]}};
        head_valid_nxt[split_ord] = 1'b1;
        head_idx_nxt[split_ord]   = buddy;
        avail_nxt = split_ord;
        if (split_ord == req_order_r) state_nxt = S_FINAL;
      end
      S_FINAL: begin
        ram_we         = 1'b1;
        ram_waddr      = blk_r;
        ram_wdata      = '{free: 1'b0, ord: req_order_r, link: '0};
        live_nxt       = live_sum;
        if (live_sum > peak_r) peak_nxt = live_sum;
        count_nxt      = count_r + 32'd1;
        res_status_nxt = ST_OK;
        res_addr_nxt   = cur_base_r + {{(ADDR_W-IDX_W-MIN_ORDER){1'b0}}, blk_r,
                         {MIN_ORDER{1'b0}}} + ADDR_W'(HEADER_BYTES);
        state_nxt      = S_DONE;
      end
      S_FCHK: begin
        if (ram_rdata.free) begin
          res_status_nxt = ST_DOUBLE;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = blk_r;
          ram_wdata = '{free: 1'b1, ord: ram_rdata.ord,
                        link: {head_valid_r[free_ord], head_idx_r[free_ord]}};
          head_valid_nxt[free_ord] = 1'b1;
          head_idx_nxt[free_ord]   = blk_r;
          live_nxt = (live_r >= free_size) ? live_r - free_size : '0;
          res_status_nxt = ST_OK;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          out_live_nxt   = live_r;
          out_peak_nxt   = peak_r;
          out_count_nxt  = count_r;
          out_sticky_nxt = sticky_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      base_cfg_r   <= '0;
      order_cfg_r  <= ORD_W'(MAX_ORDER);
      lock_r       <= 1'b0;
      cur_base_r   <= '0;
      cur_order_r  <= ORD_W'(MAX_ORDER);
      head_valid_r <= (MAX_ORDER+1)'(1) << MAX_ORDER;
      for (int i = 0; i <= MAX_ORDER; i++) head_idx_r[i] <= '0;
      live_r       <= '0;
      peak_r       <= '0;
      count_r      <= '0;
      sticky_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      base_cfg_r   <= base_cfg_nxt;
      order_cfg_r  <= order_cfg_nxt;
      lock_r       <= lock_nxt;
      cur_base_r   <= cur_base_nxt;
      cur_order_r  <= cur_order_nxt;
      head_valid_r <= head_valid_nxt;
      head_idx_r   <= head_idx_nxt;
      live_r       <= live_nxt;
      peak_r       <= peak_nxt;
      count_r      <= count_nxt;
      sticky_r     <= sticky_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    bytes_r      <= bytes_nxt;
    align_r      <= align_nxt;
    faddr_r      <= faddr_nxt;
    req_order_r  <= req_order_nxt;
    avail_r      <= avail_nxt;
    blk_r        <= blk_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_live_r   <= out_live_nxt;
    out_peak_r   <= out_peak_nxt;
    out_count_r  <= out_count_nxt;
    out_sticky_r <= out_sticky_nxt;
  end

  assign in_ready             = (state_r == S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_payload_address  = out_addr_r;
  assign out_live_bytes       = out_live_r;
  assign out_peak_bytes       = out_peak_r;
  assign out_allocation_count = out_count_r;
  assign out_exhausted_flag   = out_sticky_r;

  a_peak_covers_live: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= live_r)
    else $error("peak byte count fell below live byte count");

  a_split_above_fit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SPLIT) |-> (avail_r > req_order_r && avail_r <= cur_order_r))
    else $error("split order outside the fitted range");

  a_one_beat_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat accepted while one is in progress");

endmodule

[tb/sv/tb.sv]
module tb;
  import bba_pkg::*;

  localparam logic [1:0] OP_UNDEF = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  live;
    logic [CNT_W-1:0]  peak;
    logic [31:0]       count;
    logic              exh;
  } outcome_t;

  typedef struct {
    logic [1:0]        op;
    logic [23:0]       bytes;
    logic [15:0]       align;
    logic [ADDR_W-1:0] addr;
    bit                typed;
    logic [2:0]        status;
    logic [ADDR_W-1:0] paddr;
  } row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_addr = '0;
  logic [ADDR_W-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_opcode = '0;
  logic [23:0]       in_request_bytes = '0;
  logic [15:0]       in_request_alignment = '0;
  logic [ADDR_W-1:0] in_free_address = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        out_status;
  logic [ADDR_W-1:0] out_payload_address;
  logic [CNT_W-1:0]  out_live_bytes;
  logic [CNT_W-1:0]  out_peak_bytes;
  logic [31:0]       out_allocation_count;
  logic              out_exhausted_flag;

  buddy_block_allocator_unit uut (.*);

  always #5 clk = ~clk;

  // Mirror of the allocator.
  logic [ADDR_W-1:0] reg_base = '0;
  logic [4:0]        reg_order = 5'd20;
  logic              reg_lock = 1'b0;
  logic [ADDR_W-1:0] cur_base;
  int                cur_order;
  logic [LINK_W-1:0] head [0:MAX_ORDER];
  logic [LINK_W-1:0] link [SLOTS];
  bit                blk_free [SLOTS];
  int                blk_ord [SLOTS];
  bit                touched [SLOTS];
  longint unsigned   live_bytes, peak_bytes;
  logic [31:0]       alloc_total;
  bit                exh_sticky;

  logic [ADDR_W-1:0] held [$];
  logic [ADDR_W-1:0] handed [$];
  outcome_t          pending_q [$];

  bit failed = 1'b0;
  int s_pct = 14, r_pct = 51;
  int hold_req = 0, hold_seen = 0, hold_left = 0;
  int quiet = 0;

  function automatic int clamp_ord(int o);
    if (o < MIN_ORDER) return MIN_ORDER;
    if (o > MAX_ORDER) return MAX_ORDER;
    return o;
  endfunction

  function automatic void rebuild_region();
    cur_base = reg_base;
    cur_order = clamp_ord(reg_order);
    foreach (head[i]) head[i] = '0;
    live_bytes = 0;
    peak_bytes = 0;
    alloc_total = '0;
    exh_sticky = 1'b0;
    blk_free[0] = 1'b1;
    blk_ord[0] = cur_order;
    link[0] = '0;
    touched[0] = 1'b1;
    head[cur_order] = LINK_W'(SLOTS);
    held.delete();
  endfunction

  // Returns the block index a free would look up, or -1 if it is rejected first.
  function automatic int free_slot(logic [ADDR_W-1:0] a);
    longint unsigned rel;
    if (a < cur_base) return -1;
    rel = a - cur_base;
    if (rel >= (64'd1 << cur_order) || rel < HEADER_BYTES) return -1;
    rel -= HEADER_BYTES;
    if (rel[MIN_ORDER-1:0] != 0) return -1;
    return int'(rel >> MIN_ORDER) & (SLOTS - 1);
  endfunction

  function automatic outcome_t allocator_step(logic [1:0] op, logic [23:0] bytes,
                                              logic [15:0] align, logic [ADDR_W-1:0] a);
    outcome_t r;
    longint unsigned need;
    int o, av, b, bd;
    r = '0;
    case (op)
      OP_ALLOC: begin
        need = longint'(bytes) + HEADER_BYTES;
        if (align > ALIGN_LIMIT || need > (64'd1 << cur_order)) begin
          exh_sticky = 1'b1;
          r.status = ST_EXHAUSTED;
        end else begin
          o = MIN_ORDER;
          while ((64'd1 << o) < need) o++;
          av = o;
          while (av <= cur_order && !head[av][IDX_W]) av++;
          if (av > cur_order) begin
            exh_sticky = 1'b1;
            r.status = ST_EXHAUSTED;
          end else begin
            b = int'(head[av][IDX_W-1:0]);
            head[av] = link[b];
            while (av > o) begin
              av--;
              bd = (b + (1 << (av - MIN_ORDER))) & (SLOTS - 1);
              link[bd] = head[av];
              blk_free[bd] = 1'b1;
              blk_ord[bd] = av;
              touched[bd] = 1'b1;
              head[av] = LINK_W'(SLOTS | bd);
            end
            link[b] = '0;
            blk_free[b] = 1'b0;
            blk_ord[b] = o;
            touched[b] = 1'b1;
            live_bytes += 64'd1 << o;
            if (live_bytes > peak_bytes) peak_bytes = live_bytes;
            alloc_total++;
            r.status = ST_OK;
            r.addr = cur_base + (ADDR_W'(b) << MIN_ORDER) + HEADER_BYTES;
            held.push_back(r.addr);
            handed.push_back(r.addr);
          end
        end
      end
      OP_FREE: begin
        b = free_slot(a);
        if (b < 0) r.status = ST_NOT_OWNED;
        else if (blk_free[b]) r.status = ST_DOUBLE;
        else begin
          o = clamp_ord(blk_ord[b]);
          live_bytes = (live_bytes >= (64'd1 << o)) ? live_bytes - (64'd1 << o) : 0;
          blk_free[b] = 1'b1;
          link[b] = head[o];
          head[o] = LINK_W'(SLOTS | b);
          r.status = ST_OK;
          foreach (held[i]) if (held[i] == a) begin
            held.delete(i);
            break;
          end
        end
      end
      OP_RESET: begin
        if (reg_lock) r.status = ST_LOCKED;
        else begin
          rebuild_region();
          r.status = ST_OK;
        end
      end
      default: r.status = ST_EXHAUSTED;
    endcase
    r.live = live_bytes[CNT_W-1:0];
    r.peak = peak_bytes[CNT_W-1:0];
    r.count = alloc_total;
    r.exh = exh_sticky;
    return r;
  endfunction

  // Offers one beat; the prediction is made when the beat is taken.
  task automatic offer(row_t t);
    outcome_t o;
    if (s_pct > 0 && $urandom_range(0, 99) < s_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= t.op;
    in_request_bytes <= t.bytes;
    in_request_alignment <= t.align;
    in_free_address <= t.addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    o = allocator_step(t.op, t.bytes, t.align, t.addr);
    if (t.typed) begin
      o.status = t.status;
      o.addr = t.paddr;
    end
    pending_q.push_back(o);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [ADDR_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_BASE:  reg_base = val;
      REG_ORDER: reg_order = val[4:0];
      default:   reg_lock = val[0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic row_t random_item();
    row_t t;
    int r, b;
    t = '{default: '0};
    r = $urandom_range(0, 99);
    t.op = OP_ALLOC;
    t.bytes = 24'($urandom_range(0, 1 << $urandom_range(0, 10)));
    t.align = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
    if (r < 3) t.bytes = 24'($urandom);
    else if (r < 45) ;
    else if (r < 80 && held.size() != 0) begin
      t.op = OP_FREE;
      t.addr = held[$urandom_range(0, held.size() - 1)];
    end else if (r < 86 && handed.size() != 0) begin
      t.op = OP_FREE;
      t.addr = handed[$urandom_range(0, handed.size() - 1)];
    end else if (r < 92) begin
      t.op = OP_FREE;
      t.addr = {16'($urandom), 32'($urandom)};
      if ($urandom_range(0, 1)) t.addr = cur_base + 48'($urandom_range(0, 1 << cur_order));
    end else if (r < 95) begin
      t.op = OP_UNDEF;
      t.bytes = 24'($urandom);
      t.addr = {16'($urandom), 32'($urandom)};
    end else if (r < 98) t.op = OP_RESET;
    if (t.op == OP_FREE) begin
      b = free_slot(t.addr);
      // A header that was never written must not be looked up.
      if (b >= 0 && !touched[b]) begin
        t.op = OP_ALLOC;
        t.addr = '0;
      end
    end
    return t;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else out_ready <= ($urandom_range(0, 99) >= r_pct);
  end

  always @(posedge clk) begin
    outcome_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $error("result beat with nothing expected");
        failed = 1'b1;
      end else begin
        e = pending_q.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          failed = 1'b1;
        end
        if (out_payload_address !== e.addr) begin
          $error("payload_address: expected %h, got %h", e.addr, out_payload_address);
          failed = 1'b1;
        end
        if (out_live_bytes !== e.live) begin
          $error("live_bytes: expected %0d, got %0d", e.live, out_live_bytes);
          failed = 1'b1;
        end
        if (out_peak_bytes !== e.peak) begin
          $error("peak_bytes: expected %0d, got %0d", e.peak, out_peak_bytes);
          failed = 1'b1;
        end
        if (out_allocation_count !== e.count) begin
          $error("allocation_count: expected %0d, got %0d", e.count, out_allocation_count);
          failed = 1'b1;
        end
        if (out_exhausted_flag !== e.exh) begin
          $error("exhausted_flag: expected %0d, got %0d", e.exh, out_exhausted_flag);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  row_t directed [] = '{
    '{OP_ALLOC, 24'd0, 16'd0, '0, 1, ST_OK, 48'd64},
    '{OP_ALLOC, 24'd64, 16'd0, '0, 1, ST_OK, 48'd192},
    '{OP_ALLOC, 24'd65, 16'd64, '0, 1, ST_OK, 48'd320},
    '{OP_ALLOC, 24'd0, 16'd65, '0, 1, ST_EXHAUSTED, 48'd0},
    '{OP_ALLOC, 24'hFFFFFF, 16'hFFFF, '0, 1, ST_EXHAUSTED, 48'd0},
    '{OP_ALLOC, 24'd1048512, 16'd0, '0, 1, ST_EXHAUSTED, 48'd0},
    '{OP_FREE, 24'd0, 16'd0, 48'd0, 1, ST_NOT_OWNED, 48'd0},
    '{OP_FREE, 24'd0, 16'd0, 48'd65, 1, ST_NOT_OWNED, 48'd0},
    '{OP_FREE, 24'd0, 16'd0, 48'd32, 1, ST_NOT_OWNED, 48'd0},
    '{OP_FREE, 24'd0, 16'd0, 48'd64, 1, ST_OK, 48'd0},
    '{OP_FREE, 24'd0, 16'd0, 48'd64, 1, ST_DOUBLE, 48'd0},
    '{OP_FREE, 24'd0, 16'd0, 48'hFFFFFFFFFFFF, 1, ST_NOT_OWNED, 48'd0},
    '{OP_UNDEF, 24'hFFFFFF, 16'hFFFF, 48'hFFFFFFFFFFFF, 1, ST_EXHAUSTED, 48'd0},
    '{OP_ALLOC, 24'd1000, 16'd16, '0, 0, ST_OK, 48'd0},
    '{OP_ALLOC, 24'd3000, 16'd8, '0, 0, ST_OK, 48'd0},
    '{OP_RESET, 24'd0, 16'd0, '0, 1, ST_OK, 48'd0},
    '{OP_ALLOC, 24'd1048512, 16'd64, '0, 1, ST_OK, 48'd64},
    '{OP_ALLOC, 24'd0, 16'd0, '0, 1, ST_EXHAUSTED, 48'd0},
    '{OP_FREE, 24'd0, 16'd0, 48'd64, 1, ST_OK, 48'd0},
    '{OP_ALLOC, 24'd0, 16'd0, '0, 1, ST_OK, 48'd64},
    '{OP_FREE, 24'd0, 16'd0, 48'd192, 0, ST_OK, 48'd0},
    '{OP_ALLOC, 24'd100, 16'd32, '0, 0, ST_OK, 48'd0}
  };

  logic [ADDR_W-1:0] ph_base [5] = '{48'hFFFFFFF00000, 48'h000012345680, 48'd0,
                                     48'hABCDEF123400, 48'h800000000000};
  logic [4:0]        ph_order [5] = '{5'd20, 5'd7, 5'd31, 5'd0, 5'd12};
  logic              ph_lock [5] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

  initial begin
    row_t t;
    rebuild_region();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) offer(directed[i]);
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      s_pct = (ph < 2) ? 14 : (ph < 4) ? 51 : 0;
      r_pct = (ph < 2) ? 51 : (ph < 4) ? 14 : 0;
      cfg_write(REG_BASE, ph_base[ph]);
      cfg_write(REG_ORDER, 48'(ph_order[ph]));
      cfg_write(REG_LOCK, 48'd0);
      t = '{default: '0};
      t.op = OP_RESET;
      offer(t);
      drain();
      cfg_write(REG_LOCK, 48'(ph_lock[ph]));
      for (int n = 0; n < 366; n++) begin
        // Stop taking results for a while so the block backs up its input.
        if (n == 150 && (ph == 0 || ph == 4)) hold_req++;
        offer(random_item());
      end
      drain();
    end
    if (!failed) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
